@@ hdl/rtch_pkg.sv @@
// ============================================================================
// rtch_pkg
// Shared types, widths and the multiply-accumulate sequence for the
// closest-hit ray/triangle unit.
// ============================================================================
package rtch_pkg;

   localparam int COORD_BITS = 32;
   localparam int OBJ_BITS   = 16;
   localparam int DIST_W     = 31;

   // Edge and offset vectors are differences of two coordinates.
   localparam int DW    = COORD_BITS + 1;
   // Cross products: one sign bit of margin, rounded up to an even width.
   localparam int WW    = 2 * DW + 2;
   localparam int CH    = WW / 2;
   localparam int PW    = DW + CH + 1;
   localparam int ACC_W = DW + WW + 3;
   localparam int DIV_W = ACC_W + 31;

   localparam int N_MAC     = 24;
   localparam int N_ISSUE   = 2 * N_MAC;
   localparam int N_OPND    = 12;
   localparam int SEL_W     = 4;
   localparam int CNT_W     = 6;
   localparam int DIV_STEPS = DIST_W;

   localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

   // Configuration register indexes.
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DIR_X    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DIR_Y    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DIR_Z    = 3'd5;

   // Short operand slots (multiplier A side).
   localparam logic [SEL_W-1:0] A_DX  = 4'd0;
   localparam logic [SEL_W-1:0] A_DY  = 4'd1;
   localparam logic [SEL_W-1:0] A_DZ  = 4'd2;
   localparam logic [SEL_W-1:0] A_E1X = 4'd3;
   localparam logic [SEL_W-1:0] A_E1Y = 4'd4;
   localparam logic [SEL_W-1:0] A_E1Z = 4'd5;
   localparam logic [SEL_W-1:0] A_E2X = 4'd6;
   localparam logic [SEL_W-1:0] A_E2Y = 4'd7;
   localparam logic [SEL_W-1:0] A_E2Z = 4'd8;
   localparam logic [SEL_W-1:0] A_SX  = 4'd9;
   localparam logic [SEL_W-1:0] A_SY  = 4'd10;
   localparam logic [SEL_W-1:0] A_SZ  = 4'd11;

   // Wide operand slots (multiplier B side).
   localparam logic [SEL_W-1:0] B_E1X = 4'd0;
   localparam logic [SEL_W-1:0] B_E1Y = 4'd1;
   localparam logic [SEL_W-1:0] B_E1Z = 4'd2;
   localparam logic [SEL_W-1:0] B_E2X = 4'd3;
   localparam logic [SEL_W-1:0] B_E2Y = 4'd4;
   localparam logic [SEL_W-1:0] B_E2Z = 4'd5;
   localparam logic [SEL_W-1:0] B_HX  = 4'd6;
   localparam logic [SEL_W-1:0] B_HY  = 4'd7;
   localparam logic [SEL_W-1:0] B_HZ  = 4'd8;
   localparam logic [SEL_W-1:0] B_QX  = 4'd9;
   localparam logic [SEL_W-1:0] B_QY  = 4'd10;
   localparam logic [SEL_W-1:0] B_QZ  = 4'd11;

   // Accumulator destinations.
   localparam logic [SEL_W-1:0] D_HX  = 4'd0;
   localparam logic [SEL_W-1:0] D_HY  = 4'd1;
   localparam logic [SEL_W-1:0] D_HZ  = 4'd2;
   localparam logic [SEL_W-1:0] D_QX  = 4'd3;
   localparam logic [SEL_W-1:0] D_QY  = 4'd4;
   localparam logic [SEL_W-1:0] D_QZ  = 4'd5;
   localparam logic [SEL_W-1:0] D_DET = 4'd6;
   localparam logic [SEL_W-1:0] D_UN  = 4'd7;
   localparam logic [SEL_W-1:0] D_VN  = 4'd8;
   localparam logic [SEL_W-1:0] D_TN  = 4'd9;
   localparam logic [SEL_W-1:0] D_NONE = 4'd15;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] a_x;
      logic signed [COORD_BITS-1:0] a_y;
      logic signed [COORD_BITS-1:0] a_z;
      logic signed [COORD_BITS-1:0] b_x;
      logic signed [COORD_BITS-1:0] b_y;
      logic signed [COORD_BITS-1:0] b_z;
      logic signed [COORD_BITS-1:0] c_x;
      logic signed [COORD_BITS-1:0] c_y;
      logic signed [COORD_BITS-1:0] c_z;
      logic [OBJ_BITS-1:0]          object_id;
      logic                         last_triangle;
   } req_item_type;

   typedef struct packed {
      logic                hit_found;
      logic [OBJ_BITS-1:0] nearest_object;
      logic [DIST_W-1:0]   nearest_distance;
   } rsp_item_type;

   typedef struct packed {
      logic [SEL_W-1:0] a_sel;
      logic [SEL_W-1:0] b_sel;
      logic             sub;
      logic             first;
      logic             last;
      logic [SEL_W-1:0] dest;
   } mac_op_type;

   function automatic logic signed [DW-1:0] sx(input logic [COORD_BITS-1:0] v);
      return {v[COORD_BITS-1], v};
   endfunction

   // h = d x e2, det = e1.h, un = s.h, q = s x e1, vn = d.q, tn = e2.q
   function automatic mac_op_type mac_op(input logic [4:0] step);
      mac_op_type op;
      op = '{a_sel: A_DX, b_sel: B_E1X, sub: 1'b0, first: 1'b0, last: 1'b0, dest: D_NONE};
      unique case (step)
         5'd0:  op = '{A_DY,  B_E2Z, 1'b0, 1'b1, 1'b0, D_NONE};
         5'd1:  op = '{A_DZ,  B_E2Y, 1'b1, 1'b0, 1'b1, D_HX};
         5'd2:  op = '{A_DZ,  B_E2X, 1'b0, 1'b1, 1'b0, D_NONE};
         5'd3:  op = '{A_DX,  B_E2Z, 1'b1, 1'b0, 1'b1, D_HY};
         5'd4:  op = '{A_DX,  B_E2Y, 1'b0, 1'b1, 1'b0, D_NONE};
         5'd5:  op = '{A_DY,  B_E2X, 1'b1, 1'b0, 1'b1, D_HZ};
         5'd6:  op = '{A_E1X, B_HX,  1'b0, 1'b1, 1'b0, D_NONE};
         5'd7:  op = '{A_E1Y, B_HY,  1'b0, 1'b0, 1'b0, D_NONE};
         5'd8:  op = '{A_E1Z, B_HZ,  1'b0, 1'b0, 1'b1, D_DET};
         5'd9:  op = '{A_SX,  B_HX,  1'b0, 1'b1, 1'b0, D_NONE};
         5'd10: op = '{A_SY,  B_HY,  1'b0, 1'b0, 1'b0, D_NONE};
         5'd11: op = '{A_SZ,  B_HZ,  1'b0, 1'b0, 1'b1, D_UN};
         5'd12: op = '{A_SY,  B_E1Z, 1'b0, 1'b1, 1'b0, D_NONE};
         5'd13: op = '{A_SZ,  B_E1Y, 1'b1, 1'b0, 1'b1, D_QX};
         5'd14: op = '{A_SZ,  B_E1X, 1'b0, 1'b1, 1'b0, D_NONE};
         5'd15: op = '{A_SX,  B_E1Z, 1'b1, 1'b0, 1'b1, D_QY};
         5'd16: op = '{A_SX,  B_E1Y, 1'b0, 1'b1, 1'b0, D_NONE};
         5'd17: op = '{A_SY,  B_E1X, 1'b1, 1'b0, 1'b1, D_QZ};
         5'd18: op = '{A_DX,  B_QX,  1'b0, 1'b1, 1'b0, D_NONE};
         5'd19: op = '{A_DY,  B_QY,  1'b0, 1'b0, 1'b0, D_NONE};
         5'd20: op = '{A_DZ,  B_QZ,  1'b0, 1'b0, 1'b1, D_VN};
         5'd21: op = '{A_E2X, B_QX,  1'b0, 1'b1, 1'b0, D_NONE};
         5'd22: op = '{A_E2Y, B_QY,  1'b0, 1'b0, 1'b0, D_NONE};
         5'd23: op = '{A_E2Z, B_QZ,  1'b0, 1'b0, 1'b1, D_TN};
         default: op = '{A_DX, B_E1X, 1'b0, 1'b0, 1'b0, D_NONE};
      endcase
      return op;
   endfunction

endpackage

@@ hdl/ray_triangle_closest_hit_unit.sv @@
// ============================================================================
// ray_triangle_closest_hit_unit
// Moller-Trumbore closest-hit search of a configured ray over a stream of
// triangles, exact Q16.16 fixed point with one shared multiplier.
// ============================================================================
// Usage: write the ray origin and direction through the csr_ port (index 0..5,
// one write per cycle while the unit is idle). Then send triangles on the
// req_ channel, one item per triangle; the item with last_triangle set closes
// the query. Only that item produces an rsp_ item: the nearest object and its
// Q15.16 distance, or hit_found = 0 with zero fields when nothing was hit.
// Each triangle keeps req_ready low from its acceptance until its final step,
// so no new triangle is taken before the last one is done; a triangle that is
// rejected skips the division. The steps: the shared 33x35 multiplier forms
// the 24 products of the cross and dot terms, each as a low and a high partial
// product; the pipeline drains; ST_CHK and ST_CHK2 test the ranges; the
// restoring divider forms the 31 quotient bits of t; ST_FIN updates the best
// hit. rsp_valid rises after ST_FIN of the last triangle of a query.
// A result waits in an output register; if the receiver stalls, the unit still
// processes following triangles and only holds at the end of the next last
// triangle until the pending result is taken.
// Reset (synchronous, active high) clears the ray registers to zero and the
// search state to no hit with the maximum distance.
module ray_triangle_closest_hit_unit import rtch_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [COORD_BITS-1:0] csr_wdata,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_item_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_item_type          rsp_data
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_MAC   = 3'd1;
   localparam logic [2:0] ST_DRAIN = 3'd2;
   localparam logic [2:0] ST_CHK   = 3'd3;
   localparam logic [2:0] ST_CHK2  = 3'd4;
   localparam logic [2:0] ST_DIV   = 3'd5;
   localparam logic [2:0] ST_FIN   = 3'd6;

   // Ray registers.
   logic [COORD_BITS-1:0] origin_ff [3];
   logic [COORD_BITS-1:0] dir_ff [3];

   // Control.
   logic [2:0]       state_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             p_valid_ff;
   logic             wb_valid_ff;
   logic             rsp_valid_ff;
   logic [DIST_W-1:0]   best_dist_ff;
   logic [OBJ_BITS-1:0] best_obj_ff;
   logic                any_hit_ff;

   // Operand slots for the shared multiplier.
   logic signed [DW-1:0] a_reg_ff [N_OPND];
   logic signed [WW-1:0] b_reg_ff [N_OPND];

   // Product stage.
   logic signed [PW-1:0] p_ff;
   logic                 p_half_ff;
   logic                 p_sub_ff;
   logic                 p_first_ff;
   logic                 p_last_ff;
   logic [SEL_W-1:0]     p_dest_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic [SEL_W-1:0]        wb_dest_ff;

   // Results of the dot products; un, vn and tn are stored with the sign of
   // det folded in, det as its magnitude.
   logic signed [ACC_W-1:0] det_ff;
   logic                    det_neg_ff;
   logic signed [ACC_W-1:0] un_ff;
   logic signed [ACC_W-1:0] vn_ff;
   logic signed [ACC_W-1:0] tn_ff;
   logic                    reject_ff;

   // Divider.
   logic [DIV_W-1:0]  rem_ff;
   logic [DIV_W-1:0]  dsh_ff;
   logic [DIST_W-1:0] quo_ff;

   logic [OBJ_BITS-1:0] obj_ff;
   logic                last_ff;
   rsp_item_type        rsp_ff;

   // ---------------------------------------------------------------------
   // Datapath
   // ---------------------------------------------------------------------
   logic req_fire;
   logic signed [DW-1:0] av [3];
   logic signed [DW-1:0] e1v [3];
   logic signed [DW-1:0] e2v [3];
   logic signed [DW-1:0] sv [3];

   mac_op_type           op;
   logic                 issue;
   logic signed [DW-1:0] a_opnd;
   logic signed [WW-1:0] b_opnd;
   logic signed [CH:0]   b_chunk;
   logic signed [PW-1:0] prod;

   logic signed [ACC_W-1:0] term_lo;
   logic signed [ACC_W-1:0] term;
   logic signed [ACC_W-1:0] base;
   logic signed [ACC_W-1:0] acc_in;
   logic signed [ACC_W-1:0] acc_neg;
   logic signed [ACC_W-1:0] acc_abs;
   logic signed [ACC_W-1:0] acc_fix;

   logic signed [ACC_W+15:0] tn_wide;
   logic signed [ACC_W+15:0] det_sh15;
   logic signed [ACC_W:0]    uv_sum;
   logic signed [ACC_W:0]    det_wide;
   logic                     rej_a;
   logic                     rej_b;

   logic              div_ge;
   logic              tri_hit;
   logic              fin_stall;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      av[0]  = sx(req_data.a_x);
      av[1]  = sx(req_data.a_y);
      av[2]  = sx(req_data.a_z);
      e1v[0] = sx(req_data.b_x) - av[0];
      e1v[1] = sx(req_data.b_y) - av[1];
      e1v[2] = sx(req_data.b_z) - av[2];
      e2v[0] = sx(req_data.c_x) - av[0];
      e2v[1] = sx(req_data.c_y) - av[1];
      e2v[2] = sx(req_data.c_z) - av[2];
      sv[0]  = sx(origin_ff[0]) - av[0];
      sv[1]  = sx(origin_ff[1]) - av[1];
      sv[2]  = sx(origin_ff[2]) - av[2];
   end

   // Issue one partial product per cycle: the low chunk of B is taken as
   // unsigned, the high chunk as signed and weighted by 2^CH.
   always_comb begin
      op      = mac_op(cnt_ff[CNT_W-1:1]);
      issue   = (state_ff == ST_MAC);
      a_opnd  = a_reg_ff[op.a_sel];
      b_opnd  = b_reg_ff[op.b_sel];
      b_chunk = cnt_ff[0] ? {b_opnd[WW-1], b_opnd[WW-1:CH]} : {1'b0, b_opnd[CH-1:0]};
      prod    = a_opnd * b_chunk;
   end

   always_comb begin
      term_lo = {{(ACC_W-PW){p_ff[PW-1]}}, p_ff};
      term    = p_half_ff ? (term_lo <<< CH) : term_lo;
      base    = (p_first_ff && !p_half_ff) ? '0 : acc_ff;
      acc_in  = p_sub_ff ? (base - term) : (base + term);
      acc_neg = -acc_ff;
      acc_abs = acc_ff[ACC_W-1] ? acc_neg : acc_ff;
      acc_fix = det_neg_ff ? acc_neg : acc_ff;
   end

   // Range tests. t >= 2^15 (a quotient of 2^31 or more, saturation) can never
   // beat the best distance, so it is folded into rejection.
   always_comb begin
      tn_wide  = {{16{tn_ff[ACC_W-1]}}, tn_ff};
      det_sh15 = {det_ff[ACC_W-1], det_ff, 15'b0};
      uv_sum   = {un_ff[ACC_W-1], un_ff} + {vn_ff[ACC_W-1], vn_ff};
      det_wide = {det_ff[ACC_W-1], det_ff};
      rej_a    = (det_ff == '0) || (un_ff < 0) || (un_ff > det_ff) || (tn_ff <= 0)
                 || (tn_wide >= det_sh15);
      rej_b    = (vn_ff < 0) || (uv_sum > det_wide);
   end

   always_comb begin
      div_ge    = (rem_ff >= dsh_ff);
      tri_hit   = !reject_ff && (quo_ff != '0) && (quo_ff < best_dist_ff);
      fin_stall = last_ff && rsp_valid_ff && !rsp_ready;
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         for (int k = 0; k < 3; k++) begin
            a_reg_ff[k]     <= sx(dir_ff[k]);
            a_reg_ff[3 + k] <= e1v[k];
            a_reg_ff[6 + k] <= e2v[k];
            a_reg_ff[9 + k] <= sv[k];
            b_reg_ff[k]     <= WW'(e1v[k]);
            b_reg_ff[3 + k] <= WW'(e2v[k]);
         end
         obj_ff  <= req_data.object_id;
         last_ff <= req_data.last_triangle;
      end
      p_ff       <= prod;
      p_half_ff  <= cnt_ff[0];
      p_sub_ff   <= op.sub;
      p_first_ff <= op.first;
      p_last_ff  <= op.last;
      p_dest_ff  <= op.dest;
      if (p_valid_ff) begin
         acc_ff <= acc_in;
      end
      wb_dest_ff <= p_dest_ff;
      if (wb_valid_ff) begin
         unique case (wb_dest_ff)
            D_HX:  b_reg_ff[B_HX] <= acc_ff[WW-1:0];
            D_HY:  b_reg_ff[B_HY] <= acc_ff[WW-1:0];
            D_HZ:  b_reg_ff[B_HZ] <= acc_ff[WW-1:0];
            D_QX:  b_reg_ff[B_QX] <= acc_ff[WW-1:0];
            D_QY:  b_reg_ff[B_QY] <= acc_ff[WW-1:0];
            D_QZ:  b_reg_ff[B_QZ] <= acc_ff[WW-1:0];
            D_DET: begin
               det_ff     <= acc_abs;
               det_neg_ff <= acc_ff[ACC_W-1];
            end
            D_UN:  un_ff <= acc_fix;
            D_VN:  vn_ff <= acc_fix;
            D_TN:  tn_ff <= acc_fix;
            default: ;
         endcase
      end
      if (state_ff == ST_CHK) begin
         reject_ff <= rej_a;
      end
      if (state_ff == ST_CHK2) begin
         reject_ff <= reject_ff || rej_b;
         rem_ff    <= DIV_W'({tn_ff, 16'b0});
         dsh_ff    <= DIV_W'({det_ff, 30'b0});
         quo_ff    <= '0;
      end
      if (state_ff == ST_DIV) begin
         if (div_ge) begin
            rem_ff <= rem_ff - dsh_ff;
         end
         dsh_ff <= dsh_ff >> 1;
         quo_ff <= {quo_ff[DIST_W-2:0], div_ge};
      end
      if (state_ff == ST_FIN && !fin_stall && last_ff) begin
         if (tri_hit || any_hit_ff) begin
            rsp_ff.hit_found        <= 1'b1;
            rsp_ff.nearest_object   <= tri_hit ? obj_ff : best_obj_ff;
            rsp_ff.nearest_distance <= tri_hit ? quo_ff : best_dist_ff;
         end else begin
            rsp_ff <= '0;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         p_valid_ff   <= 1'b0;
         wb_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         best_dist_ff <= DIST_MAX;
         best_obj_ff  <= '0;
         any_hit_ff   <= 1'b0;
         for (int k = 0; k < 3; k++) begin
            origin_ff[k] <= '0;
            dir_ff[k]    <= '0;
         end
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_ORIGIN_X: origin_ff[0] <= csr_wdata;
               CSR_ORIGIN_Y: origin_ff[1] <= csr_wdata;
               CSR_ORIGIN_Z: origin_ff[2] <= csr_wdata;
               CSR_DIR_X:    dir_ff[0]    <= csr_wdata;
               CSR_DIR_Y:    dir_ff[1]    <= csr_wdata;
               CSR_DIR_Z:    dir_ff[2]    <= csr_wdata;
               default: ;
            endcase
         end

         p_valid_ff  <= issue;
         wb_valid_ff <= p_valid_ff && p_last_ff && p_half_ff;

         // A new result may replace the one being taken in the same cycle.
         if (state_ff == ST_FIN && last_ff && !fin_stall) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  state_ff <= ST_MAC;
                  cnt_ff   <= '0;
               end
            end
            ST_MAC: begin
               if (cnt_ff == CNT_W'(N_ISSUE - 1)) begin
                  state_ff <= ST_DRAIN;
               end
               cnt_ff <= cnt_ff + 1'b1;
            end
            ST_DRAIN: begin
               if (!p_valid_ff && !wb_valid_ff) begin
                  state_ff <= ST_CHK;
               end
            end
            ST_CHK: begin
               state_ff <= ST_CHK2;
            end
            ST_CHK2: begin
               cnt_ff   <= '0;
               state_ff <= (reject_ff || rej_b) ? ST_FIN : ST_DIV;
            end
            ST_DIV: begin
               if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
                  state_ff <= ST_FIN;
               end
               cnt_ff <= cnt_ff + 1'b1;
            end
            ST_FIN: begin
               if (!fin_stall) begin
                  state_ff <= ST_IDLE;
                  if (last_ff) begin
                     best_dist_ff <= DIST_MAX;
                     best_obj_ff  <= '0;
                     any_hit_ff   <= 1'b0;
                  end else if (tri_hit) begin
                     best_dist_ff <= quo_ff;
                     best_obj_ff  <= obj_ff;
                     any_hit_ff   <= 1'b1;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   // Without a hit the search state must sit at its cleared values.
   a_clear_state: assert property (@(posedge clock) disable iff (reset)
      !any_hit_ff |-> (best_dist_ff == DIST_MAX) && (best_obj_ff == '0))
      else $error("search state not cleared while no hit is held");

   // A recorded hit is always strictly closer than the saturation value.
   a_hit_dist: assert property (@(posedge clock) disable iff (reset)
      any_hit_ff |-> (best_dist_ff != DIST_MAX))
      else $error("recorded hit carries the saturated distance");

   // Accumulator writebacks only happen while the product sequence runs.
   a_wb_window: assert property (@(posedge clock) disable iff (reset)
      wb_valid_ff |-> (state_ff == ST_MAC) || (state_ff == ST_DRAIN))
      else $error("writeback outside the multiply sequence");

   // The divider never runs past its last quotient bit.
   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (cnt_ff < CNT_W'(DIV_STEPS)))
      else $error("divider step count out of range");

endmodule
